// ===== rtl/core/rpv_pkg.sv =====
// Package for the relative path validator: constants, error codes, flags.
// No dependencies.
package rpv_pkg;

   localparam int unsigned COMPONENT_LIMIT_DEFAULT = 255;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_EMPTY     = 4'd1,
      ERR_ABSOLUTE  = 4'd2,
      ERR_TRAVERSAL = 4'd3,
      ERR_UTF8      = 4'd4,
      ERR_CHAR      = 4'd5,
      ERR_TRAILING  = 4'd6,
      ERR_RESERVED  = 4'd7,
      ERR_COMP_LONG = 4'd8,
      ERR_PATH_LONG = 4'd9
   } error_type;

   localparam logic CSR_PATH_SYNTAX = 1'b0;
   localparam logic CSR_LONG_POLICY = 1'b1;

   localparam logic [12:0] LINUX_PATH_MAX  = 13'd4095;
   localparam logic [15:0] WIN_LEGACY_MAX  = 16'd259;
   localparam logic [15:0] WIN_EXTENDED_MAX = 16'd32766;

   typedef struct packed {
      logic bad_utf8;
      logic bad_char;
      logic dot_seen;
      logic non_dot;
   } flags_type;

endpackage

// ===== rtl/core/rpv_comp_check.sv =====
// Classifies a finished path component into an error code.
// Depends on rpv_pkg.
module rpv_comp_check
   import rpv_pkg::*;
#(
   parameter int unsigned COMPONENT_LIMIT = COMPONENT_LIMIT_DEFAULT,
   parameter int unsigned CW = $clog2(COMPONENT_LIMIT + 2)
) (
   input  logic            win,
   input  logic            seq_open,
   input  flags_type       flags,
   input  logic [CW-1:0]   comp_bytes,
   input  logic [CW-1:0]   comp_units,
   input  logic [7:0]      last_char,
   input  logic [7:0]      base [6],
   input  logic [2:0]      base_len,
   output error_type       code
);
   localparam logic [CW-1:0] LIM = CW'(COMPONENT_LIMIT);

   logic reserved;
   logic three;

   always_comb begin
      three = 1'b0;
      reserved = 1'b0;
      if (base_len == 3'd3) begin
         three = (base[0] == "C" && base[1] == "O" && base[2] == "N") ||
                 (base[0] == "P" && base[1] == "R" && base[2] == "N") ||
                 (base[0] == "A" && base[1] == "U" && base[2] == "X") ||
                 (base[0] == "N" && base[1] == "U" && base[2] == "L");
         reserved = three;
      end else if (base_len == 3'd6) begin
         reserved = base[0] == "C" && base[1] == "L" && base[2] == "O" &&
                    base[3] == "C" && base[4] == "K" && base[5] == "$";
      end else if (base_len == 3'd4) begin
         reserved = ((base[0] == "C" && base[1] == "O" && base[2] == "M") ||
                     (base[0] == "L" && base[1] == "P" && base[2] == "T")) &&
                    base[3] inside {["1":"9"]};
      end
   end

   always_comb begin
      code = ERR_NONE;
      if (comp_bytes == '0 || (!flags.non_dot && comp_bytes <= CW'(2)))
         code = ERR_TRAVERSAL;
      else if (flags.bad_utf8 || seq_open)
         code = ERR_UTF8;
      else if (flags.bad_char)
         code = ERR_CHAR;
      else if (win) begin
         if (last_char == "." || last_char == " ") code = ERR_TRAILING;
         else if (reserved) code = ERR_RESERVED;
         else if (comp_units > LIM) code = ERR_COMP_LONG;
      end else if (comp_bytes > LIM)
         code = ERR_COMP_LONG;
   end
endmodule

// ===== rtl/core/relative_path_validator_core.sv =====
// Relative path validator top level: byte stream in, one verdict per path out.
// Depends on rpv_pkg and rpv_comp_check.
//
// Usage: path bytes enter on req_ (valid/ready), one beat per byte, with
// req_last_byte on the final byte; req_empty_path marks a whole empty path
// (byte ignored). One verdict beat leaves on rsp_ per path: rsp_path_ok,
// rsp_error_code and rsp_component_index. Non-final bytes give no beat.
// Latency: the verdict is registered and valid the cycle after the last byte
// is accepted. Throughput: one byte per cycle while no verdict is held, set by the single registered
// per-byte update of the decode and component state.
// When the receiver stalls the verdict holds in the output register and
// req_ready stays low until it leaves; a byte is taken in the same cycle
// that the held verdict is taken.
// Configuration: csr_ writes (index 0 path syntax, 1 long path policy) are
// always accepted; write them only while idle.
// Reset: synchronous, clears all path state, the csr registers and the output valid; the verdict fields are not reset.
module relative_path_validator_core
   import rpv_pkg::*;
#(
   parameter int unsigned COMPONENT_LIMIT = COMPONENT_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_path_byte,
   input  logic        req_last_byte,
   input  logic        req_empty_path,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_path_ok,
   output logic [3:0]  rsp_error_code,
   output logic [15:0] rsp_component_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   localparam int unsigned CW = $clog2(COMPONENT_LIMIT + 2);
   localparam logic [CW-1:0] LIM = CW'(COMPONENT_LIMIT);
   localparam logic [CW-1:0] SAT = CW'(COMPONENT_LIMIT + 1);

   logic syntax_ff, policy_ff;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  first_ff, first_in;
   logic [1:0]  rem_ff, rem_in;
   logic [2:0]  slen_ff, slen_in;
   logic [20:0] acc_ff, acc_in;
   logic [CW-1:0] cb_ff, cb_in, cu_ff, cu_in;
   logic [7:0]  base_ff [6];
   logic [7:0]  base_in [6];
   logic [2:0]  blen_ff, blen_in;
   flags_type   fl_ff, fl_in;
   logic [7:0]  lc_ff, lc_in;
   logic [12:0] tb_ff, tb_in;
   logic [15:0] tu_ff, tu_in;
   logic [15:0] cc_ff, cc_in;
   error_type   fe_ff, fe_in;
   logic [15:0] fi_ff, fi_in;
   logic        ov_ff;
   logic        ook_ff, ook_in;
   error_type   oc_ff, oc_in;
   logic [15:0] oi_ff, oi_in;

   // component state including this byte (unchanged on a separator)
   logic [1:0]  chk_rem;
   logic [2:0]  chk_slen;
   logic [20:0] chk_acc;
   logic [CW-1:0] chk_cb, chk_cu;
   logic [7:0]  chk_base [6];
   logic [2:0]  chk_blen;
   flags_type   chk_fl;
   logic [7:0]  chk_lc;

   logic accept, win, sep, absolute, is_dot;
   logic [7:0] b;
   error_type comp_code;
   logic [1:0]  units;
   logic [20:0] cp;
   logic [20:0] cmin;

   assign csr_ready = 1'b1;
   assign req_ready = !ov_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign rsp_valid = ov_ff;
   assign rsp_path_ok = ook_ff;
   assign rsp_error_code = oc_ff;
   assign rsp_component_index = oi_ff;

   assign b = req_path_byte;
   assign win = syntax_ff;
   assign sep = b == "/" || (win && b == "\\");
   assign is_dot = b == ".";

   rpv_comp_check #(.COMPONENT_LIMIT(COMPONENT_LIMIT), .CW(CW)) u_check (
      .win(win), .seq_open(chk_rem != 2'd0), .flags(chk_fl),
      .comp_bytes(chk_cb), .comp_units(chk_cu), .last_char(chk_lc),
      .base(chk_base), .base_len(chk_blen), .code(comp_code)
   );

   always_comb begin
      logic [CW:0] cu_sum;

      chk_rem = rem_ff; chk_slen = slen_ff; chk_acc = acc_ff; chk_cb = cb_ff;
      chk_cu = cu_ff; chk_base = base_ff; chk_blen = blen_ff; chk_fl = fl_ff;
      chk_lc = lc_ff;
      units = 2'd0; cp = '0; cmin = '0;
      cu_sum = '0;

      if (!sep) begin
         if (cb_ff <= LIM) chk_cb = cb_ff + CW'(1);
         chk_lc = b;
         if (!is_dot) chk_fl.non_dot = 1'b1;
         if (win ? (b < 8'd32 || b == "<" || b == ">" || b == ":" || b == "\"" ||
                    b == "|" || b == "?" || b == "*") : (b == 8'd0))
            chk_fl.bad_char = 1'b1;
         if (!fl_ff.dot_seen) begin
            if (is_dot) chk_fl.dot_seen = 1'b1;
            else if (blen_ff < 3'd6) begin
               chk_base[blen_ff] = (b inside {["a":"z"]}) ? b - 8'd32 : b;
               chk_blen = blen_ff + 3'd1;
            end else chk_blen = 3'd7;
         end
         if (!fl_ff.bad_utf8) begin
            if (rem_ff == 2'd0) begin
               if (b[7] == 1'b0) units = 2'd1;
               else if (b[7:5] == 3'b110) begin
                  chk_slen = 3'd2; chk_acc = {16'd0, b[4:0]}; chk_rem = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  chk_slen = 3'd3; chk_acc = {17'd0, b[3:0]}; chk_rem = 2'd2;
               end else if (b[7:3] == 5'b11110) begin
                  chk_slen = 3'd4; chk_acc = {18'd0, b[2:0]}; chk_rem = 2'd3;
               end else chk_fl.bad_utf8 = 1'b1;
            end else if (b[7:6] != 2'b10) begin
               chk_fl.bad_utf8 = 1'b1; chk_rem = 2'd0;
            end else begin
               cp = {acc_ff[14:0], b[5:0]};
               chk_acc = cp;
               chk_rem = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  cmin = slen_ff == 3'd2 ? 21'h80 :
                         slen_ff == 3'd3 ? 21'h800 : 21'h10000;
                  if (cp < cmin || cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff))
                     chk_fl.bad_utf8 = 1'b1;
                  else units = cp > 21'hffff ? 2'd2 : 2'd1;
               end
            end
         end
         cu_sum = {1'b0, cu_ff} + (CW+1)'(units);
         chk_cu = cu_sum > (CW+1)'(SAT) ? SAT : cu_sum[CW-1:0];
      end
   end

   always_comb begin
      logic [16:0] tu_sum;
      logic end_comp, is_last;
      error_type fcode;
      logic [15:0] fidx;

      pos_in = pos_ff; first_in = first_ff; tb_in = tb_ff;
      tu_in = tu_ff; cc_in = cc_ff; fe_in = fe_ff; fi_in = fi_ff;
      rem_in = chk_rem; slen_in = chk_slen; acc_in = chk_acc; cb_in = chk_cb;
      cu_in = chk_cu; base_in = chk_base; blen_in = chk_blen; fl_in = chk_fl;
      lc_in = chk_lc;
      ook_in = ook_ff; oc_in = oc_ff; oi_in = oi_ff;
      absolute = 1'b0;
      tu_sum = '0;
      end_comp = sep;
      is_last = req_last_byte;
      fcode = ERR_NONE; fidx = '0;

      if (pos_ff == 2'd0) begin
         first_in = b;
         absolute = sep;
      end else if (pos_ff == 2'd1) begin
         absolute = win && b == ":" &&
                    (first_ff inside {["A":"Z"], ["a":"z"]});
      end
      if (absolute) begin
         fe_in = ERR_ABSOLUTE; fi_in = '0;
      end
      if (pos_ff != 2'd2) pos_in = pos_ff + 2'd1;
      if (tb_ff != 13'h1fff) tb_in = tb_ff + 13'd1;

      // separator counts as one unit in the total
      tu_sum = {1'b0, tu_ff} + 17'(sep ? 2'd1 : units);
      tu_in = tu_sum > 17'hffff ? 16'hffff : tu_sum[15:0];

      fcode = fe_in; fidx = fi_in;
      if ((end_comp || is_last) && comp_code != ERR_NONE && fcode == ERR_NONE) begin
         fcode = comp_code; fidx = cc_ff;
      end

      if (end_comp && is_last) begin
         // separator then path end: trailing empty component
         if (fcode == ERR_NONE) begin
            fcode = ERR_TRAVERSAL;
            fidx = cc_ff == 16'hffff ? cc_ff : cc_ff + 16'd1;
         end
      end

      if (req_empty_path) begin
         ook_in = 1'b0; oc_in = ERR_EMPTY; oi_in = '0;
      end else if (is_last) begin
         if (fcode == ERR_NONE) begin
            fidx = '0;
            if (!win) begin
               if (tb_in > LINUX_PATH_MAX) fcode = ERR_PATH_LONG;
            end else if (tu_in > (policy_ff ? WIN_EXTENDED_MAX : WIN_LEGACY_MAX))
               fcode = ERR_PATH_LONG;
         end
         if (fcode == ERR_ABSOLUTE || fcode == ERR_PATH_LONG) fidx = '0;
         ook_in = fcode == ERR_NONE;
         oc_in = fcode;
         oi_in = fidx;
      end

      if (req_empty_path || is_last) begin
         pos_in = '0; first_in = '0; tb_in = '0; tu_in = '0; cc_in = '0;
         fe_in = ERR_NONE; fi_in = '0;
      end else begin
         fe_in = fcode; fi_in = fidx;
         if (end_comp && cc_ff != 16'hffff) cc_in = cc_ff + 16'd1;
      end
      if (req_empty_path || is_last || end_comp) begin
         rem_in = '0; slen_in = '0; acc_in = '0; cb_in = '0; cu_in = '0;
         for (int i = 0; i < 6; i++) base_in[i] = '0;
         blen_in = '0; fl_in = '0; lc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         syntax_ff <= 1'b0; policy_ff <= 1'b0;
         pos_ff <= '0; first_ff <= '0; rem_ff <= '0; slen_ff <= '0;
         acc_ff <= '0; cb_ff <= '0; cu_ff <= '0; blen_ff <= '0;
         fl_ff <= '0; lc_ff <= '0; tb_ff <= '0; tu_ff <= '0; cc_ff <= '0;
         fe_ff <= ERR_NONE; fi_ff <= '0; ov_ff <= 1'b0;
         for (int i = 0; i < 6; i++) base_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_PATH_SYNTAX) syntax_ff <= csr_data[0];
            else policy_ff <= csr_data[0];
         end
         if (accept && (req_empty_path || req_last_byte)) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
         if (accept) begin
            pos_ff <= pos_in; first_ff <= first_in; rem_ff <= rem_in;
            slen_ff <= slen_in; acc_ff <= acc_in; cb_ff <= cb_in; cu_ff <= cu_in;
            base_ff <= base_in; blen_ff <= blen_in; fl_ff <= fl_in; lc_ff <= lc_in;
            tb_ff <= tb_in; tu_ff <= tu_in; cc_ff <= cc_in;
            fe_ff <= fe_in; fi_ff <= fi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_empty_path || req_last_byte)) begin
         ook_ff <= ook_in; oc_ff <= oc_in; oi_ff <= oi_in;
      end
   end
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for relative_path_validator_core: byte-stream paths in,
// one verdict per path out, checked against an in-bench path checker.
// Depends on rpv_pkg and the core RTL.
`timescale 1ns / 100ps

class verdict_board;
   bit          syntax_win;
   bit          long_policy;
   int unsigned byte_pos, first_b, seq_rem, seq_len, code_acc;
   int unsigned comp_bytes, comp_units, base_len, last_char;
   byte unsigned base[6];
   bit          f_utf8, f_char, f_dot, f_nondot;
   int unsigned tot_bytes, tot_units, comp_cnt, first_err, first_idx;
   bit [20:0]   exp_q[$];
   int          errors;
   int          verdicts;

   function void clear_comp();
      seq_rem = 0; seq_len = 0; code_acc = 0; comp_bytes = 0; comp_units = 0;
      foreach (base[i]) base[i] = 0;
      base_len = 0; last_char = 0;
      f_utf8 = 0; f_char = 0; f_dot = 0; f_nondot = 0;
   endfunction

   function void clear_path();
      clear_comp();
      byte_pos = 0; first_b = 0; tot_bytes = 0; tot_units = 0; comp_cnt = 0;
      first_err = 0; first_idx = 0;
   endfunction

   function bit base_eq(string s);
      if (base_len != s.len()) return 0;
      for (int i = 0; i < s.len(); i++)
         if (base[i] != s[i]) return 0;
      return 1;
   endfunction

   function bit is_device();
      if (base_eq("CON") || base_eq("PRN") || base_eq("AUX") || base_eq("NUL") ||
          base_eq("CLOCK$"))
         return 1;
      if (base_len == 4 && ((base[0] == "C" && base[1] == "O" && base[2] == "M") ||
                            (base[0] == "L" && base[1] == "P" && base[2] == "T")))
         return base[3] >= "1" && base[3] <= "9";
      return 0;
   endfunction

   function void add_units(int unsigned n);
      comp_units += n;
      if (comp_units > 256) comp_units = 256;
      tot_units += n;
      if (tot_units > 65535) tot_units = 65535;
   endfunction

   function void close_comp();
      rpv_pkg::error_type c;
      c = rpv_pkg::ERR_NONE;
      if (seq_rem != 0) f_utf8 = 1;
      if (comp_bytes == 0 || (!f_nondot && comp_bytes <= 2)) c = rpv_pkg::ERR_TRAVERSAL;
      else if (f_utf8) c = rpv_pkg::ERR_UTF8;
      else if (f_char) c = rpv_pkg::ERR_CHAR;
      else if (syntax_win) begin
         if (last_char == "." || last_char == " ") c = rpv_pkg::ERR_TRAILING;
         else if (is_device()) c = rpv_pkg::ERR_RESERVED;
         else if (comp_units > 255) c = rpv_pkg::ERR_COMP_LONG;
      end else if (comp_bytes > 255) c = rpv_pkg::ERR_COMP_LONG;
      if (c != rpv_pkg::ERR_NONE && first_err == 0) begin
         first_err = c;
         first_idx = comp_cnt;
      end
      clear_comp();
      if (comp_cnt < 65535) comp_cnt++;
   endfunction

   function void decode(int unsigned b);
      int unsigned cp, lo;
      if (f_utf8) return;
      if (seq_rem == 0) begin
         if (b < 'h80) begin
            add_units(1);
            return;
         end
         if ((b & 'he0) == 'hc0) begin
            seq_len = 2; code_acc = b & 'h1f;
         end else if ((b & 'hf0) == 'he0) begin
            seq_len = 3; code_acc = b & 'h0f;
         end else if ((b & 'hf8) == 'hf0) begin
            seq_len = 4; code_acc = b & 'h07;
         end else begin
            f_utf8 = 1;
            return;
         end
         seq_rem = seq_len - 1;
         return;
      end
      if ((b & 'hc0) != 'h80) begin
         f_utf8 = 1; seq_rem = 0;
         return;
      end
      code_acc = ((code_acc << 6) | (b & 'h3f)) & 'h1fffff;
      seq_rem--;
      if (seq_rem == 0) begin
         cp = code_acc;
         lo = seq_len == 2 ? 'h80 : seq_len == 3 ? 'h800 : 'h10000;
         if (cp < lo || cp > 'h10ffff || (cp >= 'hd800 && cp <= 'hdfff)) f_utf8 = 1;
         else add_units(cp > 'hffff ? 2 : 1);
      end
   endfunction

   function void comp_byte(int unsigned b);
      if (comp_bytes <= 255) comp_bytes++;
      last_char = b;
      if (b != ".") f_nondot = 1;
      if (syntax_win ? (b < 32 || b == "<" || b == ">" || b == ":" || b == "\"" ||
                        b == "|" || b == "?" || b == "*") : (b == 0))
         f_char = 1;
      if (!f_dot) begin
         if (b == ".") f_dot = 1;
         else if (base_len < 6) begin
            base[base_len] = 8'((b >= "a" && b <= "z") ? b - 32 : b);
            base_len++;
         end else base_len = 7;
      end
      decode(b);
   endfunction

   function void note_byte(bit [7:0] b, bit last, bit empty);
      bit abs_hit;
      int unsigned code, idx;
      abs_hit = 0;
      if (empty) begin
         clear_path();
         exp_q.push_back({1'b0, rpv_pkg::ERR_EMPTY, 16'd0});
         return;
      end
      if (byte_pos == 0) begin
         first_b = b;
         if (b == "/" || (syntax_win && b == "\\")) abs_hit = 1;
      end else if (byte_pos == 1) begin
         if (syntax_win && b == ":" && ((first_b >= "A" && first_b <= "Z") ||
                                        (first_b >= "a" && first_b <= "z")))
            abs_hit = 1;
      end
      if (abs_hit) begin
         first_err = rpv_pkg::ERR_ABSOLUTE; first_idx = 0;
      end
      if (byte_pos < 2) byte_pos++;
      if (tot_bytes < 8191) tot_bytes++;
      if (b == "/" || (syntax_win && b == "\\")) begin
         close_comp();
         if (tot_units < 65535) tot_units++;
      end else comp_byte(b);
      if (!last) return;
      close_comp();
      code = first_err;
      idx = first_idx;
      if (code == 0) begin
         if (!syntax_win) begin
            if (tot_bytes > 4095) code = rpv_pkg::ERR_PATH_LONG;
         end else if (tot_units > (long_policy ? 32766 : 259)) code = rpv_pkg::ERR_PATH_LONG;
         idx = 0;
      end
      if (code == rpv_pkg::ERR_ABSOLUTE || code == rpv_pkg::ERR_PATH_LONG) idx = 0;
      exp_q.push_back({code == 0, code[3:0], idx[15:0]});
      clear_path();
   endfunction

   function void check_verdict(bit ok, bit [3:0] code, bit [15:0] idx);
      bit [20:0] e;
      verdicts++;
      if (exp_q.size() == 0) begin
         $display("%0t: verdict with none expected: ok=%0d code=%0d idx=%0d",
                  $realtime, ok, code, idx);
         errors++;
         return;
      end
      e = exp_q.pop_front();
      if (e[20] != ok) begin
         $display("%0t: path_ok exp %0d got %0d", $realtime, e[20], ok);
         errors++;
      end
      if (e[19:16] != code) begin
         $display("%0t: error_code exp %0d got %0d", $realtime, e[19:16], code);
         errors++;
      end
      if (e[15:0] != idx) begin
         $display("%0t: component_index exp %0d got %0d", $realtime, e[15:0], idx);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import rpv_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready, req_last_byte, req_empty_path;
   logic [7:0]  req_path_byte;
   logic        rsp_valid, rsp_ready, rsp_path_ok;
   logic [3:0]  rsp_error_code;
   logic [15:0] rsp_component_index;
   logic        csr_valid, csr_ready, csr_index;
   logic [31:0] csr_data;

   verdict_board board;
   int unsigned  cycles;
   int unsigned  beats;
   bit           rsp_hold;
   int           rsp_wait;

   relative_path_validator_core DUT (.*);

   initial clock = 0;
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: checks verdicts and after each one may hold rsp_ready low at random, unless rsp_hold is set.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_verdict(rsp_path_ok, rsp_error_code, rsp_component_index);
            rsp_wait = $urandom_range(0, 6);
         end
         if (rsp_hold || rsp_wait == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end
      end
   end

   task automatic send_beat(bit [7:0] b, bit last, bit empty, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_path_byte <= b;
      req_last_byte <= last;
      req_empty_path <= empty;
      do @(posedge clock); while (!req_ready);
      board.note_byte(b, last, empty);
      beats++;
   endtask

   task automatic send_path(string s, int burst);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], i == s.len() - 1, 1'b0, burst ? 0 : $urandom_range(0, 6));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.exp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, bit val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= {$urandom} & 32'hffff_fffe | 32'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PATH_SYNTAX) board.syntax_win = val;
      else board.long_policy = val;
   endtask

   function automatic string rand_comp(int kind);
      string s;
      string pool[] = '{"a", "B", "z", ".", " ", "-", "_", "0", "9", "\xc3\xa9",
                        "\xe2\x82\xac", "\xf0\x9f\x98\x80"};
      int n;
      s = "";
      case (kind)
         0: return ".";
         1: return "..";
         2: return "con";
         3: return "LPT7.txt";
         default: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 15) == 0) s = {s, string'(8'($urandom))};
               else s = {s, pool[$urandom_range(0, pool.size() - 1)]};
            end
            return s;
         end
      endcase
   endfunction

   task automatic random_paths(int count);
      string p;
      int nc, burst;
      for (int k = 0; k < count; k++) begin
         burst = $urandom_range(0, 3) == 0;
         if ($urandom_range(0, 15) == 0) begin
            send_beat(8'($urandom), 1'($urandom), 1'b1, $urandom_range(0, 6));
            continue;
         end
         nc = $urandom_range(1, 4);
         p = "";
         for (int c = 0; c < nc; c++) begin
            if (c) p = {p, ($urandom_range(0, 1) ? "\\" : "/")};
            p = {p, rand_comp($urandom_range(0, 20))};
         end
         if ($urandom_range(0, 9) == 0) begin
            // partial path cut by an empty-path beat
            for (int i = 0; i < p.len(); i++)
               send_beat(p[i], 1'b0, 1'b0, $urandom_range(0, 6));
            send_beat(8'hff, 1'($urandom), 1'b1, 0);
         end else send_path(p, burst);
      end
   endtask

   task automatic long_path(int comps, int clen, bit [7:0] fill);
      string c, p;
      c = "";
      p = "";
      for (int i = 0; i < clen; i++) c = {c, string'(fill)};
      for (int i = 0; i < comps; i++) p = (i == 0) ? c : {p, "/", c};
      send_path(p, 1);
   endtask

   initial begin
      board = new();
      board.clear_path();
      reset = 1'b1;
      req_valid = 0; req_path_byte = 0; req_last_byte = 0; req_empty_path = 0;
      rsp_ready = 0; csr_valid = 0; csr_index = 0; csr_data = 0;
      rsp_hold = 0; rsp_wait = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_PATH_SYNTAX, 1'b0);
      write_csr(CSR_LONG_POLICY, 1'b0);
      send_path("a/b.c", 0);
      send_path("/abs", 0);
      send_path("a//b", 0);
      send_path("x/../y", 0);
      send_path("\xc0\x80", 0);
      send_path("\xed\xa0\x80", 0);
      send_path("\xf4\x90\x80\x80", 0);
      send_path("\xe2\x82", 0);
      send_path("a/\xc3", 0);
      send_path("q/", 0);
      send_beat(8'h00, 1'b1, 1'b0, 0);
      send_beat(8'hff, 1'b1, 1'b1, 0);
      long_path(1, 256, "q");
      write_csr(CSR_PATH_SYNTAX, 1'b1);
      send_path("C:x", 0);
      send_path("\\x", 0);
      send_path("a?b", 0);
      send_path("dir/name.", 0);
      send_path("com1.log", 0);
      send_path("Clock$", 0);
      send_path("ok\\fine", 0);
      long_path(2, 130, "r");
      write_csr(CSR_LONG_POLICY, 1'b1);
      send_path("ok\\fine", 0);

      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_PATH_SYNTAX, ph[0]);
         write_csr(CSR_LONG_POLICY, ph[1]);
         if (ph == 2) begin
            rsp_hold = 1;
            random_paths(3);
            drain();
            rsp_hold = 0;
         end
         random_paths(3);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d input beats and %0d verdicts over both syntaxes and policies.",
               beats, board.verdicts);
      if (board.errors == 0 && board.exp_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
